[design/sfrp_pkg.sv]
package sfrp_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_FIRST   = 3'd0,
    CFG_HEADER_SECOND  = 3'd1,
    CFG_TRAILER_FIRST  = 3'd2,
    CFG_TRAILER_SECOND = 3'd3,
    CFG_SEARCH_LIMIT   = 3'd4
  } cfg_reg_t;

  localparam logic [7:0] SEARCH_LIMIT_RST = 8'd28;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] trailer_first;
    logic [7:0] trailer_second;
    logic [7:0] search_limit;
  } cfg_t;

  // hunt / body tracking in the front end
  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  // body byte positions
  localparam logic [3:0] WORD0_BASE  = 4'd4;
  localparam logic [3:0] WORD1_BASE  = 4'd6;
  localparam logic [3:0] WORD2_BASE  = 4'd8;
  localparam logic [3:0] TRAILER_IDX = 4'd10;
  localparam logic [3:0] BODY_LAST   = 4'd11;

  typedef enum logic [1:0] {
    CMD_BODY    = 2'd0,
    CMD_LAST    = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] idx;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_GOOD     = 2'd0,
    OUT_MISMATCH = 2'd1,
    OUT_TIMEOUT  = 2'd2
  } outcome_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [31:0] record_counter;
    logic [15:0] word_zero;
    logic [15:0] word_one;
    logic [15:0] word_two;
    logic [5:0]  batch_slot;
    logic        batch_done;
    logic [31:0] errors_seen;
  } result_t;

endpackage

[design/sfrp_fifo.sv]
module sfrp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[design/sfrp_front.sv]
module sfrp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  sfrp_pkg::cfg_t     cfg,
  input  logic               byte_take,
  input  logic [7:0]         rx_byte,
  output logic               cmd_push,
  output sfrp_pkg::cmd_t     cmd
);

  sfrp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       body_index_r, body_index_nxt;
  logic [7:0]       search_count_r, search_count_nxt;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (byte_take) begin
      case (phase_r)
        sfrp_pkg::PH_HUNT2: begin
          phase_nxt = (rx_byte == cfg.header_second) ? sfrp_pkg::PH_BODY
                                                     : sfrp_pkg::PH_HUNT1;
        end
        sfrp_pkg::PH_BODY: begin
          phase_nxt = (body_index_r == sfrp_pkg::BODY_LAST) ? sfrp_pkg::PH_HUNT1
                                                            : sfrp_pkg::PH_BODY;
        end
        default: begin
          phase_nxt = (rx_byte == cfg.header_first) ? sfrp_pkg::PH_HUNT2
                                                    : sfrp_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  // commands and counters
  always_comb begin
    cmd_push         = 1'b0;
    cmd.kind         = sfrp_pkg::CMD_BODY;
    cmd.idx          = body_index_r;
    cmd.data         = rx_byte;
    body_index_nxt   = body_index_r;
    search_count_nxt = search_count_r;
    if (byte_take) begin
      case (phase_r)
        sfrp_pkg::PH_HUNT2: begin
          if (rx_byte == cfg.header_second) begin
            body_index_nxt   = '0;
            search_count_nxt = '0;
          end
        end
        sfrp_pkg::PH_BODY: begin
          cmd_push = 1'b1;
          if (body_index_r == sfrp_pkg::BODY_LAST) begin
            cmd.kind       = sfrp_pkg::CMD_LAST;
            body_index_nxt = '0;
          end else begin
            body_index_nxt = body_index_r + 1'b1;
          end
        end
        default: begin
          if (rx_byte != cfg.header_first) begin
            search_count_nxt = search_count_r + 1'b1;
            if (search_count_r > cfg.search_limit) begin
              cmd_push = 1'b1;
              cmd.kind = sfrp_pkg::CMD_TIMEOUT;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= sfrp_pkg::PH_HUNT1;
      body_index_r   <= '0;
      search_count_r <= '0;
    end else begin
      phase_r        <= phase_nxt;
      body_index_r   <= body_index_nxt;
      search_count_r <= search_count_nxt;
    end
  end

endmodule

[design/sfrp_back.sv]
module sfrp_back #(
  parameter int unsigned BATCH_SIZE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfrp_pkg::cfg_t     cfg,
  input  logic               cmd_empty,
  input  sfrp_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output sfrp_pkg::result_t  res
);

  localparam logic [6:0] BATCH_LIM = 7'(BATCH_SIZE);

  logic [31:0] counter_shift_r, counter_shift_nxt;
  logic [15:0] word0_r, word0_nxt;
  logic [15:0] word1_r, word1_nxt;
  logic [15:0] word2_r, word2_nxt;
  logic [7:0]  trailer_hold_r, trailer_hold_nxt;
  logic [31:0] error_count_r, error_count_nxt;
  logic [5:0]  slot_count_r, slot_count_nxt;
  logic [6:0]  slot_sum;
  logic        take;
  logic        trailer_ok;

  assign take       = !cmd_empty && !res_full;
  assign cmd_pop    = take;
  assign res_push   = take && (cmd.kind != sfrp_pkg::CMD_BODY);
  assign slot_sum   = {1'b0, slot_count_r} + 7'd1;
  assign trailer_ok = (trailer_hold_r == cfg.trailer_first) &&
                      (cmd.data == cfg.trailer_second);

  always_comb begin
    counter_shift_nxt = counter_shift_r;
    word0_nxt         = word0_r;
    word1_nxt         = word1_r;
    word2_nxt         = word2_r;
    trailer_hold_nxt  = trailer_hold_r;
    error_count_nxt   = error_count_r;
    slot_count_nxt    = slot_count_r;
    res               = '0;
    if (take) begin
      case (cmd.kind)
        sfrp_pkg::CMD_BODY: begin
          if (cmd.idx < sfrp_pkg::WORD0_BASE) begin
            counter_shift_nxt = {counter_shift_r[23:0], cmd.data};
          end else if (cmd.idx < sfrp_pkg::WORD1_BASE) begin
            word0_nxt = {word0_r[7:0], cmd.data};
          end else if (cmd.idx < sfrp_pkg::WORD2_BASE) begin
            word1_nxt = {word1_r[7:0], cmd.data};
          end else if (cmd.idx < sfrp_pkg::TRAILER_IDX) begin
            word2_nxt = {word2_r[7:0], cmd.data};
          end else begin
            trailer_hold_nxt = cmd.data;
          end
        end
        sfrp_pkg::CMD_LAST: begin
          if (trailer_ok) begin
            res.outcome        = sfrp_pkg::OUT_GOOD;
            res.record_counter = counter_shift_r;
            res.word_zero      = word0_r;
            res.word_one       = word1_r;
            res.word_two       = word2_r;
            res.batch_slot     = slot_count_r;
            if (slot_sum >= BATCH_LIM) begin
              res.batch_done = 1'b1;
              slot_count_nxt = '0;
            end else begin
              slot_count_nxt = slot_sum[5:0];
            end
          end else begin
            error_count_nxt = error_count_r + 32'd1;
            res.outcome     = sfrp_pkg::OUT_MISMATCH;
          end
          res.errors_seen = error_count_nxt;
        end
        sfrp_pkg::CMD_TIMEOUT: begin
          error_count_nxt = error_count_r + 32'd1;
          res.outcome     = sfrp_pkg::OUT_TIMEOUT;
          res.errors_seen = error_count_nxt;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_count_r <= '0;
      slot_count_r  <= '0;
    end else begin
      error_count_r <= error_count_nxt;
      slot_count_r  <= slot_count_nxt;
    end
  end

  // frame assembly registers are fully rewritten by every frame
  always_ff @(posedge clk) begin
    counter_shift_r <= counter_shift_nxt;
    word0_r         <= word0_nxt;
    word1_r         <= word1_nxt;
    word2_r         <= word2_nxt;
    trailer_hold_r  <= trailer_hold_nxt;
  end

endmodule

[design/sync_framed_record_parser_top.sv]
// sync framed record parser: takes one received serial byte per transfer on
// the in_ queue port (in_push / in_full), hunts for a two-byte sync header,
// collects a twelve-byte body and delivers one result per finished frame or
// per sync-search timeout on the out_ queue port (out_empty / out_pop).
// configuration is a separate valid/ready write channel (cfg_index selects
// header, trailer and search-limit registers); cfg_ready is always high and
// writes are meant for a quiet block.
// throughput: one byte per cycle, sustained while the result queue has room,
// set by the front byte classifier and the back frame assembler.
// result path: the byte that causes a result is written as a command into
// the command queue; the back end then moves its result into the result
// queue, whose head drives the out_ ports, once that queue has room.
// when the receiver stalls the result queue fills, the back end stops
// draining commands, the command queue fills and in_full rises.
// reset (synchronous, active low) empties both queues, returns to hunting
// for the first header byte and clears the search, error and batch counts;
// configuration registers return to their defaults (search limit 28).
module sync_framed_record_parser_top #(
  parameter int unsigned BATCH_SIZE = 8,
  parameter int unsigned CMD_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH  = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte input
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [7:0]                     in_rx_byte,
  // results
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [1:0]                     out_outcome,
  output logic [31:0]                    out_record_counter,
  output logic [15:0]                    out_word_zero,
  output logic [15:0]                    out_word_one,
  output logic [15:0]                    out_word_two,
  output logic [5:0]                     out_batch_slot,
  output logic                           out_batch_done,
  output logic [31:0]                    out_errors_seen,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  localparam int unsigned CMD_W = $bits(sfrp_pkg::cmd_t);
  localparam int unsigned RES_W = $bits(sfrp_pkg::result_t);

  sfrp_pkg::cfg_t    cfg_r, cfg_nxt;
  sfrp_pkg::cmd_t    front_cmd, back_cmd;
  sfrp_pkg::result_t back_res, head_res;
  logic              front_push;
  logic              cmd_empty, cmd_pop;
  logic              res_full, res_push;
  logic              byte_take;

  // configuration registers, writes always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        sfrp_pkg::CFG_HEADER_FIRST:   cfg_nxt.header_first   = cfg_data;
        sfrp_pkg::CFG_HEADER_SECOND:  cfg_nxt.header_second  = cfg_data;
        sfrp_pkg::CFG_TRAILER_FIRST:  cfg_nxt.trailer_first  = cfg_data;
        sfrp_pkg::CFG_TRAILER_SECOND: cfg_nxt.trailer_second = cfg_data;
        sfrp_pkg::CFG_SEARCH_LIMIT:   cfg_nxt.search_limit   = cfg_data;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first   <= '0;
      cfg_r.header_second  <= '0;
      cfg_r.trailer_first  <= '0;
      cfg_r.trailer_second <= '0;
      cfg_r.search_limit   <= sfrp_pkg::SEARCH_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a byte is taken whenever the command queue has room
  assign byte_take = in_push && !in_full;

  sfrp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .byte_take (byte_take),
    .rx_byte   (in_rx_byte),
    .cmd_push  (front_push),
    .cmd       (front_cmd)
  );

  // command queue between classifier and assembler
  sfrp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  sfrp_back #(
    .BATCH_SIZE (BATCH_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // result queue, head drives the out_ ports
  sfrp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (head_res),
    .empty (out_empty)
  );

  assign out_outcome        = head_res.outcome;
  assign out_record_counter = head_res.record_counter;
  assign out_word_zero      = head_res.word_zero;
  assign out_word_one       = head_res.word_one;
  assign out_word_two       = head_res.word_two;
  assign out_batch_slot     = head_res.batch_slot;
  assign out_batch_done     = head_res.batch_done;
  assign out_errors_seen    = head_res.errors_seen;

endmodule
